// ===== src/pidc_pkg.sv =====
package pidc_pkg;

  // Default depth of the hit list
  localparam int HIT_CAPACITY_DEF = 64;

  localparam int ID_W       = 24;
  localparam int BYTE_W     = 8;
  localparam int TOTAL_W    = 7;
  localparam int TOTAL_MAX  = 127;

  // Entries in the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Classified pixel request handed from front to back
  typedef struct packed {
    logic            first_pixel;
    logic            is_bg;
    logic [ID_W-1:0] cand;
  } item_t;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_t;

endpackage

// ===== src/pick_id_dedup_collector_unit.sv =====
// Object-id picking hit collector.
// Input channel (in_valid / in_stall): one request per pixel of an object-id
// render target, three color bytes plus a first-pixel mark. The id is
// {red, green, blue}; id zero is background. A nonzero id gives the object
// index id - 1, which is appended to the hit list unless already present.
// Result channel (out_valid / out_stall): exactly one result per request, in
// order: new_hit, hit_object, hit_total (saturating at 127), the sticky
// overflow flag and the single-select done flag.
// Config: cfg_wr_en / cfg_wr_data write single_select; write only when idle.
// Timing: a front stage registers and classifies each request, a two-entry
// queue decouples it from the back end, which searches the hit list one
// entry per cycle through the single-port list memory. A background,
// stopped or first-in-list request is answered without a search; a search
// reads the listed entries in order until a match or the end of the list.
// Each result is held in the output register until the receiver takes it.
// Reset clears the count, stop and overflow flags and single_select; list
// contents are not cleared, only entries below the count are ever read.
// When the receiver stalls, the result holds in the output register, the
// back end waits, and the front keeps filling the queue until it is full.
module pick_id_dedup_collector_unit #(
  parameter int HIT_CAPACITY = pidc_pkg::HIT_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_first_pixel,
  input  logic [pidc_pkg::BYTE_W-1:0]   in_blue_byte,
  input  logic [pidc_pkg::BYTE_W-1:0]   in_green_byte,
  input  logic [pidc_pkg::BYTE_W-1:0]   in_red_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_new_hit,
  output logic [pidc_pkg::ID_W-1:0]     out_hit_object,
  output logic [pidc_pkg::TOTAL_W-1:0]  out_hit_total,
  output logic                          out_list_overflow,
  output logic                          out_collection_done
);
  import pidc_pkg::*;

  logic  single_select_r;
  logic  fr_valid;
  logic  fr_stall;
  item_t fr_item;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  // Mode register; hold until the next write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_select_r <= 1'b0;
    end else if (cfg_wr_en) begin
      single_select_r <= cfg_wr_data;
    end
  end

  // Register the pixel, form the id and classify it
  pidc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_first_pixel (in_first_pixel),
    .in_blue_byte   (in_blue_byte),
    .in_green_byte  (in_green_byte),
    .in_red_byte    (in_red_byte),
    .fr_valid       (fr_valid),
    .fr_stall       (fr_stall),
    .fr_item        (fr_item)
  );

  // Decouple the front from the list search
  pidc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_stall (fr_stall),
    .wr_item  (fr_item),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_item  (q_item)
  );

  // Search, append and drive the result register
  pidc_back #(
    .HIT_CAPACITY (HIT_CAPACITY)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .single_select       (single_select_r),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_item              (q_item),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_new_hit         (out_new_hit),
    .out_hit_object      (out_hit_object),
    .out_hit_total       (out_hit_total),
    .out_list_overflow   (out_list_overflow),
    .out_collection_done (out_collection_done)
  );

endmodule

// ===== src/pidc_front.sv =====
module pidc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_first_pixel,
  input  logic [pidc_pkg::BYTE_W-1:0]  in_blue_byte,
  input  logic [pidc_pkg::BYTE_W-1:0]  in_green_byte,
  input  logic [pidc_pkg::BYTE_W-1:0]  in_red_byte,
  output logic                         fr_valid,
  input  logic                         fr_stall,
  output pidc_pkg::item_t              fr_item
);
  import pidc_pkg::*;

  logic            valid_r;
  logic            valid_nxt;
  item_t           item_r;
  logic [ID_W-1:0] id;
  logic            accept;

  assign id       = {in_red_byte, in_green_byte, in_blue_byte};
  assign in_stall = valid_r && fr_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !fr_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Classify: background test and object index (id minus one)
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.first_pixel <= in_first_pixel;
      item_r.is_bg       <= (id == '0);
      item_r.cand        <= id - ID_W'(1);
    end
  end

  assign fr_valid = valid_r;
  assign fr_item  = item_r;

endmodule

// ===== src/pidc_queue.sv =====
module pidc_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_stall,
  input  pidc_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_pop,
  output pidc_pkg::item_t rd_item
);
  import pidc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] wptr_nxt;
  logic [PTR_W-1:0] rptr_r;
  logic [PTR_W-1:0] rptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             push;
  logic             pop;

  assign wr_stall = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push     = wr_valid && !wr_stall;
  assign rd_valid = (cnt_r != '0);
  assign pop      = rd_pop && rd_valid;
  assign rd_item  = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (32'(wptr_r) == QUEUE_DEPTH - 1) ? '0 : wptr_r + PTR_W'(1);
    end
    if (pop) begin
      rptr_nxt = (32'(rptr_r) == QUEUE_DEPTH - 1) ? '0 : rptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wr_item;
    end
  end

endmodule

// ===== src/pidc_back.sv =====
module pidc_back #(
  parameter int HIT_CAPACITY = pidc_pkg::HIT_CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          single_select,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  pidc_pkg::item_t               q_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_new_hit,
  output logic [pidc_pkg::ID_W-1:0]     out_hit_object,
  output logic [pidc_pkg::TOTAL_W-1:0]  out_hit_total,
  output logic                          out_list_overflow,
  output logic                          out_collection_done
);
  import pidc_pkg::*;

  localparam int IDX_W = (HIT_CAPACITY > 1) ? $clog2(HIT_CAPACITY) : 1;
  localparam int CNT_W = $clog2(HIT_CAPACITY + 1);

  back_state_t      state_r;
  back_state_t      state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             stop_r;
  logic             stop_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  item_t            item_r;
  item_t            item_nxt;
  logic [IDX_W-1:0] iss_r;
  logic [IDX_W-1:0] iss_nxt;
  logic             iss_done_r;
  logic             iss_done_nxt;
  logic             chk_r;
  logic             chk_nxt;

  logic [ID_W-1:0]  mem [HIT_CAPACITY];
  logic [ID_W-1:0]  mem_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [ID_W-1:0]  wr_data;

  logic             do_ins;
  logic [CNT_W-1:0] ins_cnt;
  logic [CNT_W-1:0] eff_cnt;
  logic             eff_stop;
  logic             emit;
  logic             res_new;
  logic [ID_W-1:0]  res_obj;

  logic             out_valid_r;
  logic             out_new_r;
  logic [ID_W-1:0]  out_obj_r;
  logic [TOTAL_W-1:0] out_total_r;
  logic             out_ovf_r;
  logic             out_done_r;

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    stop_nxt     = stop_r;
    ovf_nxt      = ovf_r;
    item_nxt     = item_r;
    iss_nxt      = iss_r;
    iss_done_nxt = iss_done_r;
    chk_nxt      = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = iss_r;
    wr_en        = 1'b0;
    wr_addr      = '0;
    wr_data      = item_r.cand;
    q_pop        = 1'b0;
    emit         = 1'b0;
    do_ins       = 1'b0;
    ins_cnt      = count_r;
    res_new      = 1'b0;
    res_obj      = '0;
    eff_cnt      = item_r.first_pixel ? '0 : count_r;
    eff_stop     = 1'b0;

    case (state_r)
      BK_IDLE: begin
        eff_cnt  = q_item.first_pixel ? '0 : count_r;
        eff_stop = q_item.first_pixel ? 1'b0 : stop_r;
        wr_data  = q_item.cand;
        if (q_valid && !out_valid_r) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          count_nxt = eff_cnt;
          stop_nxt  = eff_stop;
          if (eff_stop || q_item.is_bg) begin
            emit = 1'b1;
          end else if (eff_cnt == '0) begin
            do_ins  = 1'b1;
            ins_cnt = eff_cnt;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = '0;
            chk_nxt      = 1'b1;
            iss_nxt      = IDX_W'(1);
            iss_done_nxt = (eff_cnt == CNT_W'(1));
            state_nxt    = BK_SCAN;
          end
        end
      end
      BK_SCAN: begin
        if (chk_r && mem_q == item_r.cand) begin
          // duplicate: list unchanged
          emit      = 1'b1;
          state_nxt = BK_IDLE;
        end else if (iss_done_r) begin
          do_ins    = 1'b1;
          ins_cnt   = count_r;
          state_nxt = BK_IDLE;
        end else begin
          rd_en        = 1'b1;
          rd_addr      = iss_r;
          chk_nxt      = 1'b1;
          iss_nxt      = iss_r + IDX_W'(1);
          iss_done_nxt = (CNT_W'(iss_r) + CNT_W'(1) == count_r);
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    // Append a new index, or flag overflow when the list is full
    if (do_ins) begin
      emit = 1'b1;
      if (ins_cnt < CNT_W'(HIT_CAPACITY)) begin
        wr_en     = 1'b1;
        wr_addr   = ins_cnt[IDX_W-1:0];
        count_nxt = ins_cnt + CNT_W'(1);
        res_new   = 1'b1;
        res_obj   = wr_data;
        stop_nxt  = single_select;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      count_r <= '0;
      stop_r  <= 1'b0;
      ovf_r   <= 1'b0;
      chk_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      stop_r  <= stop_nxt;
      ovf_r   <= ovf_nxt;
      chk_r   <= chk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    iss_r      <= iss_nxt;
    iss_done_r <= iss_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_new_r   <= res_new;
      out_obj_r   <= res_obj;
      out_total_r <= (32'(count_nxt) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX)
                                                  : TOTAL_W'(count_nxt);
      out_ovf_r   <= ovf_nxt;
      out_done_r  <= stop_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_hit         = out_new_r;
  assign out_hit_object      = out_obj_r;
  assign out_hit_total       = out_total_r;
  assign out_list_overflow   = out_ovf_r;
  assign out_collection_done = out_done_r;

endmodule
